// ===== rtl/core/can_txq_pkg.sv =====
// Shared types, constants and helpers for the CAN transmit frame queue.
package can_txq_pkg;

  // Default number of frame slots
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  localparam int unsigned ID_W      = 29;
  localparam int unsigned STD_ID_W  = 11;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned PAYLOAD_W = 64;
  localparam int unsigned OVF_W     = 16;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(8);
  localparam logic [OVF_W-1:0] OVF_MAX = '1;

  // Item opcodes
  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_SERVICE = 1'b1
  } op_t;

  // Stored frame header, 34 bits
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             ext;
    logic [ID_W-1:0]  id;
  } header_t;

  // Keep the low len bytes of a payload, len already clamped to 0..8
  function automatic logic [PAYLOAD_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [PAYLOAD_W-1:0] m;
    m = '0;
    for (int b = 0; b < PAYLOAD_W / 8; b++) begin
      if (LEN_W'(b) < len) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/can_transmit_frame_queue.sv =====
// Top level of the CAN transmit frame queue: frame memories, pointers and send control.
//
// Usage: an item (enqueue or service tick) is taken on any cycle with start
// high; busy never rises, so one item is accepted every clock. Each item gives
// exactly one result, shown for one cycle with done high, in the cycle right
// after the item was taken; the receiver cannot stall it. The result delay
// is the registered read port of the frame memories: a service item reads the
// oldest slot at the taking edge and the frame appears with done. The frame
// memories need no clearing pass after reset; a slot is only read once written.
module can_transmit_frame_queue #(
  parameter int unsigned QUEUE_DEPTH = can_txq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 op,
  input  logic [can_txq_pkg::ID_W-1:0]         frame_id,
  input  logic                                 extended,
  input  logic [can_txq_pkg::LEN_W-1:0]        length,
  input  logic [can_txq_pkg::PAYLOAD_W-1:0]    payload,
  input  logic                                 tx_complete,
  input  logic                                 bus_off,
  output logic                                 done,
  output logic                                 accepted,
  output logic                                 send_valid,
  output logic [can_txq_pkg::ID_W-1:0]         send_id,
  output logic                                 send_extended,
  output logic [can_txq_pkg::LEN_W-1:0]        send_length,
  output logic [can_txq_pkg::PAYLOAD_W-1:0]    send_payload,
  output logic                                 clear_request,
  output logic                                 reinit_request,
  output logic [can_txq_pkg::OVF_W-1:0]        overflow_total
);
  import can_txq_pkg::*;

  localparam int unsigned SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_DEPTH - 1);

  // Frame memories
  logic [PAYLOAD_W-1:0] payload_mem [QUEUE_DEPTH];
  header_t              header_mem  [QUEUE_DEPTH];
  logic [PAYLOAD_W-1:0] payload_rd;
  header_t              header_rd;

  // Pointers: slot index plus wrap bit
  logic [SLOT_W-1:0] wr_slot, rd_slot;
  logic              wr_wrap, rd_wrap;
  logic [OVF_W-1:0]  overflow_counter;
  logic              tx_busy;

  logic take, is_enq, is_svc, empty, full;
  logic do_write, do_flush, do_pop, do_clear;
  header_t              hdr_in;
  logic [LEN_W-1:0]     len_clamped;
  logic [PAYLOAD_W-1:0] payload_in;

  assign busy   = 1'b0;
  assign take   = start && !busy;
  assign is_enq = (op_t'(op) == OP_ENQUEUE);
  assign is_svc = (op_t'(op) == OP_SERVICE);
  assign empty  = (wr_slot == rd_slot) && (wr_wrap == rd_wrap);
  assign full   = (wr_slot == rd_slot) && (wr_wrap != rd_wrap);

  assign do_write = take && is_enq && !full;
  assign do_flush = take && is_enq && full;
  assign do_pop   = take && is_svc && !tx_busy && !empty;
  assign do_clear = take && is_svc && tx_busy && tx_complete;

  // Frame normalization on enqueue
  always_comb begin
    len_clamped = (length > MAX_LEN) ? MAX_LEN : length;
    hdr_in.len  = len_clamped;
    hdr_in.ext  = extended;
    hdr_in.id   = extended ? frame_id : {{(ID_W-STD_ID_W){1'b0}}, frame_id[STD_ID_W-1:0]};
    payload_in  = payload & byte_mask(len_clamped);
  end

  // Payload memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (do_write) begin
      payload_mem[wr_slot] <= payload_in;
    end
    payload_rd <= payload_mem[rd_slot];
  end

  // Header memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (do_write) begin
      header_mem[wr_slot] <= hdr_in;
    end
    header_rd <= header_mem[rd_slot];
  end

  // Pointers, overflow count, transmitter state
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_slot          <= '0;
      wr_wrap          <= 1'b0;
      rd_slot          <= '0;
      rd_wrap          <= 1'b0;
      overflow_counter <= '0;
      tx_busy          <= 1'b0;
    end else begin
      if (do_write) begin
        if (wr_slot == LAST_SLOT) begin
          wr_slot <= '0;
          wr_wrap <= !wr_wrap;
        end else begin
          wr_slot <= wr_slot + 1'b1;
        end
      end
      if (do_flush) begin
        rd_slot <= wr_slot;
        rd_wrap <= wr_wrap;
        if (overflow_counter != OVF_MAX) begin
          overflow_counter <= overflow_counter + 1'b1;
        end
      end
      if (do_pop) begin
        if (rd_slot == LAST_SLOT) begin
          rd_slot <= '0;
          rd_wrap <= !rd_wrap;
        end else begin
          rd_slot <= rd_slot + 1'b1;
        end
        tx_busy <= 1'b1;
      end else if (do_clear) begin
        tx_busy <= 1'b0;
      end
    end
  end

  // Result flags, one beat per taken item
  always_ff @(posedge clk) begin
    if (rst) begin
      done           <= 1'b0;
      accepted       <= 1'b0;
      send_valid     <= 1'b0;
      clear_request  <= 1'b0;
      reinit_request <= 1'b0;
    end else begin
      done           <= take;
      accepted       <= do_write;
      send_valid     <= do_pop;
      clear_request  <= do_clear;
      reinit_request <= take && is_svc && bus_off;
    end
  end

  // Popped frame comes straight off the memory read registers
  assign send_id        = send_valid ? header_rd.id  : '0;
  assign send_extended  = send_valid ? header_rd.ext : 1'b0;
  assign send_length    = send_valid ? header_rd.len : '0;
  assign send_payload   = send_valid ? payload_rd    : '0;
  assign overflow_total = overflow_counter;

endmodule

// ===== rtl/core/can_txq_checker.sv =====
// Port-level checks for the CAN transmit frame queue, bound to the top level.
module can_txq_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 done,
  input logic                                 accepted,
  input logic                                 send_valid,
  input logic [can_txq_pkg::LEN_W-1:0]        send_length,
  input logic                                 clear_request,
  input logic [can_txq_pkg::OVF_W-1:0]        overflow_total
);
  import can_txq_pkg::*;

  // Every taken item gives a result beat in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("taken item produced no result beat");

  // No result beat without a taken item
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result beat without a taken item");

  // A beat carries at most one of stored, popped, cleared
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    done |-> ($countones({accepted, send_valid, clear_request}) <= 1))
    else $error("conflicting actions in one result beat");

  // A popped frame never carries more than eight bytes
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    send_valid |-> (send_length <= MAX_LEN))
    else $error("popped frame length above eight");

  // Overflow total never drops outside reset
  a_ovf_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (overflow_total >= $past(overflow_total)))
    else $error("overflow total decreased");

endmodule

bind can_transmit_frame_queue can_txq_checker u_can_txq_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .accepted       (accepted),
  .send_valid     (send_valid),
  .send_length    (send_length),
  .clear_request  (clear_request),
  .overflow_total (overflow_total)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the CAN transmit frame queue.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import can_txq_pkg::*;

  localparam int unsigned DEPTH      = QUEUE_DEPTH_DEF;
  localparam int unsigned PW         = $clog2(DEPTH) + 1;
  localparam int unsigned STALL_MAX  = 2000;
  localparam int unsigned RAND_BEATS = 1200;
  localparam int unsigned MAX_PRINTS = 40;
  // Enough back-to-back frames to overflow the queue twice
  localparam int unsigned OVF_FRAMES = (DEPTH + 1) * 2;

  // One input beat
  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  id;
    logic             ext;
    logic [LEN_W-1:0] len;
    logic [63:0]      pay;
    logic             txc;
    logic             boff;
  } txq_beat_t;

  // One result beat
  typedef struct packed {
    logic             acc;
    logic             sent;
    logic [ID_W-1:0]  id;
    logic             ext;
    logic [LEN_W-1:0] len;
    logic [63:0]      pay;
    logic             clr;
    logic             reinit;
    logic [OVF_W-1:0] ovf;
  } txq_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 op = 1'b0;
  logic [ID_W-1:0]      frame_id = '0;
  logic                 extended = 1'b0;
  logic [LEN_W-1:0]     length = '0;
  logic [PAYLOAD_W-1:0] payload = '0;
  logic                 tx_complete = 1'b0;
  logic                 bus_off = 1'b0;
  logic                 done;
  logic                 accepted;
  logic                 send_valid;
  logic [ID_W-1:0]      send_id;
  logic                 send_extended;
  logic [LEN_W-1:0]     send_length;
  logic [PAYLOAD_W-1:0] send_payload;
  logic                 clear_request;
  logic                 reinit_request;
  logic [OVF_W-1:0]     overflow_total;

  can_transmit_frame_queue u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  txq_beat_t   pending_beats[$];
  txq_result_t due_results[$];
  int          gap_pct = 35;
  logic        taken = 1'b0;
  int          errors = 0;
  int          stall_cycles = 0;

  // Shadow copy of the frame store, pointers and send state
  header_t          hdr_mem [DEPTH];
  logic [63:0]      pay_mem [DEPTH];
  logic [PW-1:0]    wr_ptr = '0;
  logic [PW-1:0]    rd_ptr = '0;
  logic [OVF_W-1:0] ovf_cnt = '0;
  logic             tx_busy = 1'b0;

  int n_enq = 0, n_drop = 0, n_tick = 0, n_sent = 0, n_clear = 0, n_reinit = 0;

  // Apply one accepted beat to the shadow state and return the result it gives
  function automatic txq_result_t predict_txq(input txq_beat_t b);
    txq_result_t      r;
    logic [PW-1:0]    fill;
    logic [LEN_W-1:0] len_c;
    logic [ID_W-1:0]  id_c;
    logic [63:0]      keep;
    header_t          h;
    r = '0;
    fill = wr_ptr - rd_ptr;
    if (b.op == OP_ENQUEUE) begin
      n_enq++;
      if (fill >= DEPTH) begin
        // full: drop the frame and flush everything queued
        if (ovf_cnt != OVF_MAX) ovf_cnt++;
        rd_ptr = wr_ptr;
        n_drop++;
      end else begin
        len_c = (b.len > MAX_LEN) ? MAX_LEN : b.len;
        id_c = b.id;
        if (!b.ext) id_c[ID_W-1:STD_ID_W] = '0;
        keep = (len_c >= MAX_LEN) ? '1 : ((64'd1 << (8 * len_c)) - 64'd1);
        h.len = len_c;
        h.ext = b.ext;
        h.id = id_c;
        hdr_mem[wr_ptr[PW-2:0]] = h;
        pay_mem[wr_ptr[PW-2:0]] = b.pay & keep;
        wr_ptr++;
        r.acc = 1'b1;
      end
    end else begin
      n_tick++;
      if (!tx_busy) begin
        if (fill != 0) begin
          h = hdr_mem[rd_ptr[PW-2:0]];
          r.sent = 1'b1;
          r.id = h.id;
          r.ext = h.ext;
          r.len = h.len;
          r.pay = pay_mem[rd_ptr[PW-2:0]];
          rd_ptr++;
          tx_busy = 1'b1;
          n_sent++;
        end
      end else if (b.txc) begin
        r.clr = 1'b1;
        tx_busy = 1'b0;
        n_clear++;
      end
      if (b.boff) begin
        r.reinit = 1'b1;
        n_reinit++;
      end
    end
    r.ovf = ovf_cnt;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_PRINTS)
        $display("%0d ns: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Monitor: check each result beat, record each accepted input beat
  always @(posedge clk) begin : mon
    txq_beat_t   cur;
    txq_result_t got;
    txq_result_t want;
    if (!rst) begin
      if (done) begin
        got = '{accepted, send_valid, send_id, send_extended, send_length, send_payload,
                clear_request, reinit_request, overflow_total};
        if (due_results.size() == 0) begin
          errors++;
          $display("%0d ns: result beat with nothing expected, actual %0h", $time, got);
        end else begin
          want = due_results.pop_front();
          check_field("accepted", 64'(want.acc), 64'(got.acc));
          check_field("send_valid", 64'(want.sent), 64'(got.sent));
          check_field("send_id", 64'(want.id), 64'(got.id));
          check_field("send_extended", 64'(want.ext), 64'(got.ext));
          check_field("send_length", 64'(want.len), 64'(got.len));
          check_field("send_payload", want.pay, got.pay);
          check_field("clear_request", 64'(want.clr), 64'(got.clr));
          check_field("reinit_request", 64'(want.reinit), 64'(got.reinit));
          check_field("overflow_total", 64'(want.ovf), 64'(got.ovf));
        end
      end
      taken <= start && !busy;
      if (start && !busy) begin
        cur = '{op_t'(op), frame_id, extended, length, payload, tx_complete, bus_off};
        due_results.push_back(predict_txq(cur));
      end
      // watchdog on cycles where no beat moves on either side
      if (done || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("Timeout: no beat for %0d cycles", STALL_MAX);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Driver: present the next pending beat at the falling edge, hold until taken
  always @(negedge clk) begin : drv
    txq_beat_t b;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= gap_pct) begin
        b = pending_beats.pop_front();
        op <= b.op;
        frame_id <= b.id;
        extended <= b.ext;
        length <= b.len;
        payload <= b.pay;
        tx_complete <= b.txc;
        bus_off <= b.boff;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic txq_beat_t frame(logic [ID_W-1:0] id, logic ext, logic [LEN_W-1:0] len,
                                      logic [63:0] pay);
    return '{OP_ENQUEUE, id, ext, len, pay, 1'($urandom), 1'($urandom)};
  endfunction

  function automatic txq_beat_t rand_frame();
    return frame(ID_W'($urandom), 1'($urandom), LEN_W'($urandom_range(15)),
                 {$urandom, $urandom});
  endfunction

  function automatic txq_beat_t tick(logic txc, logic boff);
    return '{OP_SERVICE, ID_W'($urandom), 1'($urandom), LEN_W'($urandom), {$urandom, $urandom},
             txc, boff};
  endfunction

  // Keep the pending list short so phase settings track the driver closely
  task automatic push_beat(input txq_beat_t b);
    while (pending_beats.size() >= 16) @(posedge clk);
    pending_beats.push_back(b);
  endtask

  initial begin : stim
    int n_rand;
    int n;
    int kind;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: field extremes, pops, completions, bus-off, idle ticks
    push_beat(frame('1, 1'b0, 4'd15, '1));
    push_beat(txq_beat_t'{OP_ENQUEUE, '1, 1'b1, 4'd8, '1, 1'b1, 1'b1});
    push_beat(frame('0, 1'b1, 4'd0, '1));
    push_beat(frame(ID_W'(29'h0012345), 1'b0, 4'd3, 64'h0123456789ABCDEF));
    push_beat(frame(ID_W'(29'h1ABCDE01), 1'b1, 4'd9, '0));
    push_beat(tick(1'b1, 1'b0));
    push_beat(tick(1'b0, 1'b0));
    push_beat(tick(1'b0, 1'b1));
    push_beat(tick(1'b1, 1'b0));
    push_beat(tick(1'b1, 1'b0));
    push_beat(tick(1'b1, 1'b1));
    for (int i = 0; i < 3; i++) begin
      push_beat(tick(1'b0, 1'b0));
      push_beat(tick(1'b1, 1'b0));
    end
    push_beat(tick(1'b1, 1'b0));
    push_beat(tick(1'b0, 1'b0));
    push_beat(tick(1'b0, 1'b1));

    // Random: bursts of frames, pop/complete sequences and some noise
    n_rand = 0;
    while (n_rand < RAND_BEATS) begin
      gap_pct = (n_rand >= 500 && n_rand < 800) ? 0 : 35;
      kind = $urandom_range(9);
      if (kind <= 3) begin
        n = $urandom_range(1, 6);
        repeat (n) push_beat(rand_frame());
      end else if (kind == 4) begin
        n = $urandom_range(12, 20);
        repeat (n) push_beat(rand_frame());
      end else if (kind <= 7) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          push_beat(tick(1'($urandom), $urandom_range(7) == 0));
          if ($urandom_range(3) == 0) push_beat(tick(1'b0, $urandom_range(7) == 0));
          push_beat(tick(1'b1, $urandom_range(7) == 0));
        end
        n = n * 2;
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(1)) push_beat(rand_frame());
          else push_beat(tick(1'($urandom), 1'($urandom)));
        end
      end
      n_rand += n;
    end

    // Frames only, mostly back-to-back, enough to overflow the queue twice
    gap_pct = 0;
    for (int i = 0; i < OVF_FRAMES; i++) push_beat(rand_frame());
    gap_pct = 35;
    push_beat(rand_frame());
    push_beat(tick(1'b0, 1'b0));
    push_beat(tick(1'b1, 1'b1));
    push_beat(tick(1'b1, 1'b0));

    // Drain: all beats sent and all results back, then a short settle
    while (pending_beats.size() != 0 || start || due_results.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);

    $display("Covered %0d enqueues (%0d dropped on a full queue), %0d service ticks,",
             n_enq, n_drop, n_tick);
    $display("%0d frames sent, %0d completions, %0d bus-off reports, overflow count %0d",
             n_sent, n_clear, n_reinit, ovf_cnt);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/can_txq_pkg.sv
rtl/core/can_transmit_frame_queue.sv
rtl/core/can_txq_checker.sv
dv/tb_top.sv
